// ===== design/cma_pkg.sv =====
package cma_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned CODE_W     = 12;
  localparam int unsigned OFFS_W     = 10;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned SAMPLE_MAX = 4095;
  localparam int unsigned MV_MAX     = 32767;

  // 3072 / 4096 reduced to lowest terms.
  localparam int unsigned CAL_NUM = 3;
  localparam int unsigned CAL_DEN = 4;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [CODE_W-1:0] BG_STORED_RST   = 12'd1229;
  localparam logic [CODE_W-1:0] BG_MEASURED_RST = 12'd1241;
  localparam logic [OFFS_W-1:0] VOLT_OFFS_RST   = 10'd20;
  localparam logic [OFFS_W-1:0] CURR_OFFS_RST   = 10'd100;

  typedef enum logic [1:0] {
    REG_BG_STORED,
    REG_BG_MEASURED,
    REG_VOLT_OFFS,
    REG_CURR_OFFS
  } cma_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_DONE
  } cma_state_e;

  typedef struct packed {
    logic [CODE_W-1:0] bgap_factory;
    logic [CODE_W-1:0] bg_measured;
    logic [OFFS_W-1:0] volt_offs;
    logic [OFFS_W-1:0] curr_offs;
  } cma_cfg_t;

  typedef struct packed {
    logic push;
    logic chan;
  } cma_shift_t;

endpackage

// ===== design/cma_in_if.sv =====
interface cma_in_if import cma_pkg::*; ();

  logic                valid;
  logic                ready;
  logic                channel;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);

endinterface

// ===== design/cma_out_if.sv =====
interface cma_out_if import cma_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic                   channel_out;
  logic [CODE_W-1:0]      mean_code;
  logic signed [MV_W-1:0] millivolts;
  logic                   saturated;
  logic                   calibration_fault;

  modport source (output valid, output channel_out, output mean_code, output millivolts,
                  output saturated, output calibration_fault, input ready);
  modport sink   (input valid, input channel_out, input mean_code, input millivolts,
                  input saturated, input calibration_fault, output ready);

endinterface

// ===== design/cma_cell.sv =====
module cma_cell import cma_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cma_shift_t          shift_i,
  input  logic [SAMPLE_W-1:0] volt_i,
  input  logic [SAMPLE_W-1:0] curr_i,
  output logic [SAMPLE_W-1:0] volt_o,
  output logic [SAMPLE_W-1:0] curr_o
);

  logic [SAMPLE_W-1:0] volt_q, volt_d;
  logic [SAMPLE_W-1:0] curr_q, curr_d;

  always_comb begin
    volt_d = volt_q;
    curr_d = curr_q;
    if (shift_i.push) begin
      if (shift_i.chan) begin
        curr_d = curr_i;
      end else begin
        volt_d = volt_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volt_q <= '0;
      curr_q <= '0;
    end else begin
      volt_q <= volt_d;
      curr_q <= curr_d;
    end
  end

  assign volt_o = volt_q;
  assign curr_o = curr_q;

endmodule

// ===== design/cma_regs.sv =====
module cma_regs import cma_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cma_cfg_t              cfg_o
);

  cma_cfg_t cfg_q, cfg_d;
  cma_reg_e reg_idx;
  logic     wr_en;

  assign reg_idx = cma_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_BG_STORED:   cfg_d.bgap_factory = pwdata[CODE_W-1:0];
        REG_BG_MEASURED: cfg_d.bg_measured  = pwdata[CODE_W-1:0];
        REG_VOLT_OFFS:   cfg_d.volt_offs    = pwdata[OFFS_W-1:0];
        REG_CURR_OFFS:   cfg_d.curr_offs    = pwdata[OFFS_W-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BG_STORED:   prdata = APB_DATA_W'(cfg_q.bgap_factory);
      REG_BG_MEASURED: prdata = APB_DATA_W'(cfg_q.bg_measured);
      REG_VOLT_OFFS:   prdata = APB_DATA_W'(cfg_q.volt_offs);
      REG_CURR_OFFS:   prdata = APB_DATA_W'(cfg_q.curr_offs);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bgap_factory <= BG_STORED_RST;
      cfg_q.bg_measured  <= BG_MEASURED_RST;
      cfg_q.volt_offs    <= VOLT_OFFS_RST;
      cfg_q.curr_offs    <= CURR_OFFS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/cma_divider.sv =====
module cma_divider import cma_pkg::*; #(
  parameter int unsigned WINDOW = 20
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start_i,
  input  logic [$clog2(WINDOW*SAMPLE_MAX+1)+CODE_W+1:0] num_i,
  input  logic [$clog2(CAL_DEN*WINDOW*SAMPLE_MAX+1)-1:0] den_i,
  input  logic [$clog2(WINDOW*SAMPLE_MAX+1)-1:0]        sum_i,
  output logic                                         done_o,
  output logic [$clog2(WINDOW*SAMPLE_MAX+1)+CODE_W+1:0] quot_o,
  output logic [CODE_W-1:0]                            mean_o
);

  localparam int unsigned SUM_W = $clog2(WINDOW*SAMPLE_MAX+1);
  localparam int unsigned NUM_W = SUM_W + CODE_W + 2;
  localparam int unsigned DEN_W = $clog2(CAL_DEN*WINDOW*SAMPLE_MAX+1);
  localparam int unsigned CNT_W = $clog2(NUM_W);

  // Reciprocal of the window length, exact for every sum of SUM_W bits.
  localparam int unsigned     RCP_SH = SUM_W + $clog2(WINDOW);
  localparam int unsigned     RCP_W  = SUM_W + 1;
  localparam longint unsigned RCP_L  =
    ((64'd1 << RCP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RCP_W-1:0] RCP   = RCP_W'(RCP_L);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic [CODE_W-1:0] mean_q, mean_d;

  logic [DEN_W:0]             trial;
  logic                       fit;
  logic [SUM_W+RCP_W-1:0]     mprod;

  // The calibration quotient comes from a restoring divider, one bit per cycle.
  // The window mean is a multiply by the reciprocal of the window length.
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fit   = trial >= {1'b0, den_q};
  assign mprod = (SUM_W+RCP_W)'(sum_i) * (SUM_W+RCP_W)'(RCP);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    mean_d = mean_q;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      mean_d = CODE_W'(mprod >> RCP_SH);
    end else if (busy_q) begin
      quo_d = {quo_q[NUM_W-2:0], fit};
      rem_d = fit ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    mean_q <= mean_d;
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign quot_o = quo_q;
  assign mean_o = mean_q;

endmodule

// ===== design/calibrated_moving_average_adc.sv =====
// An accepted sample passes through ST_MUL (the product is registered), ST_START and
// ST_DIV, and its result is loaded into the output register in ST_DONE.
// A new sample is accepted only in ST_IDLE, after the last result has been loaded. The
// bit-serial divider produces one quotient bit per cycle; ST_DONE waits while the output stalls.
// Reset clears both sample chains, both running sums and the control state, and
// loads the calibration registers with their default codes.
module calibrated_moving_average_adc import cma_pkg::*; #(
  parameter int unsigned WINDOW = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cma_in_if.sink                smp_i,
  cma_out_if.source             res_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned SUM_W  = $clog2(WINDOW*SAMPLE_MAX+1);
  localparam int unsigned PROD_W = SUM_W + CODE_W;
  localparam int unsigned NUM_W  = PROD_W + 2;
  localparam int unsigned DEN_W  = $clog2(CAL_DEN*WINDOW*SAMPLE_MAX+1);

  cma_cfg_t   cfg;
  cma_state_e state_q, state_d;
  cma_shift_t shift;

  logic accept, div_start, out_load;

  logic [SAMPLE_W-1:0] volt_tap [WINDOW];
  logic [SAMPLE_W-1:0] curr_tap [WINDOW];

  logic [SUM_W-1:0]  sum_q [2];
  logic [SUM_W-1:0]  sum_new;
  logic [SAMPLE_W-1:0] oldest;
  logic              ch_q;
  logic [PROD_W-1:0] prod_q;

  logic [NUM_W-1:0]  div_num;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [NUM_W-1:0]  quot;
  logic [CODE_W-1:0] mean;

  logic [OFFS_W-1:0]      offs;
  logic                   fault, over;
  logic signed [MV_W-1:0] mv;

  logic                   out_valid_q;
  logic                   out_ch_q;
  logic [CODE_W-1:0]      out_mean_q;
  logic signed [MV_W-1:0] out_mv_q;
  logic                   out_sat_q;
  logic                   out_fault_q;

  cma_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (smp_i.valid) state_d = ST_MUL;
      ST_MUL:   state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || res_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    smp_i.ready = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE:  smp_i.ready = 1'b1;
      ST_START: div_start = 1'b1;
      ST_DONE:  out_load = !out_valid_q || res_o.ready;
      default:  ;
    endcase
  end

  assign accept     = smp_i.valid && smp_i.ready;
  assign shift.push = accept;
  assign shift.chan = smp_i.channel;

  // Every cell hands its sample to the next on a push; the last cell holds the
  // sample that leaves the window.
  for (genvar k = 0; k < WINDOW; k++) begin : g_chain
    if (k == 0) begin : g_head
      cma_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .volt_i  (smp_i.sample),
        .curr_i  (smp_i.sample),
        .volt_o  (volt_tap[k]),
        .curr_o  (curr_tap[k])
      );
    end else begin : g_body
      cma_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .volt_i  (volt_tap[k-1]),
        .curr_i  (curr_tap[k-1]),
        .volt_o  (volt_tap[k]),
        .curr_o  (curr_tap[k])
      );
    end
  end

  assign oldest  = smp_i.channel ? curr_tap[WINDOW-1] : volt_tap[WINDOW-1];
  assign sum_new = sum_q[smp_i.channel] - SUM_W'(oldest) + SUM_W'(smp_i.sample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sum_q[0] <= '0;
      sum_q[1] <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        sum_q[smp_i.channel] <= sum_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q <= smp_i.channel;
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_W'(sum_q[ch_q]) * PROD_W'(cfg.bgap_factory);
    end
  end

  assign div_num = NUM_W'(prod_q) * NUM_W'(CAL_NUM);
  assign div_den = DEN_W'(cfg.bg_measured) * DEN_W'(CAL_DEN * WINDOW);

  cma_divider #(
    .WINDOW (WINDOW)
  ) u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .sum_i   (sum_q[ch_q]),
    .done_o  (div_done),
    .quot_o  (quot),
    .mean_o  (mean)
  );

  // The quotient is never negative but may lie below the offset, giving a negative result; only the upper limit clips.
  assign offs  = ch_q ? cfg.curr_offs : cfg.volt_offs;
  assign fault = cfg.bg_measured == '0;
  assign over  = quot > (NUM_W'(MV_MAX) + NUM_W'(offs));
  assign mv    = over ? MV_W'(MV_MAX) : MV_W'(quot - NUM_W'(offs));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_ch_q    <= ch_q;
      out_mean_q  <= mean;
      out_mv_q    <= fault ? '0 : mv;
      out_sat_q   <= !fault && over;
      out_fault_q <= fault;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.channel_out       = out_ch_q;
  assign res_o.mean_code         = out_mean_q;
  assign res_o.millivolts        = out_mv_q;
  assign res_o.saturated         = out_sat_q;
  assign res_o.calibration_fault = out_fault_q;

endmodule
